[sv/assert_macros.svh]
// assertion macros shared by the clamp rtl
// needs clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/jocl_pkg.sv]
// shared types, register codes, reset values and divider step for the clamp
// no dependencies
package jocl_pkg;

	localparam int LAT   = 7;
	localparam int IDX_W = 3;
	localparam int NUM_W = 21;
	localparam int DEN_W = 15;
	localparam int Q_W   = 7;

	typedef enum logic [IDX_W-1:0] {
		REG_TRIG_DZ,
		REG_TRIG_CEIL,
		REG_MAIN_DZ,
		REG_MAIN_RAD,
		REG_MAIN_DIAG,
		REG_SUB_DZ,
		REG_SUB_RAD,
		REG_SUB_DIAG
	} reg_idx_t;

	localparam logic [7:0] RST_TRIG_DZ   = 8'd30;
	localparam logic [7:0] RST_TRIG_CEIL = 8'd180;
	localparam logic [6:0] RST_MAIN_DZ   = 7'd15;
	localparam logic [6:0] RST_MAIN_RAD  = 7'd72;
	localparam logic [6:0] RST_MAIN_DIAG = 7'd40;
	localparam logic [6:0] RST_SUB_DZ    = 7'd15;
	localparam logic [6:0] RST_SUB_RAD   = 7'd59;
	localparam logic [6:0] RST_SUB_DIAG  = 7'd31;

	typedef struct packed {
		logic [7:0] trig_dz;
		logic [7:0] trig_ceil;
		logic [6:0] main_dz;
		logic [6:0] main_rad;
		logic [6:0] main_diag;
		logic [6:0] sub_dz;
		logic [6:0] sub_rad;
		logic [6:0] sub_diag;
	} cfg_t;

	typedef struct packed {
		logic [6:0] dz;
		logic [6:0] rad;
		logic [6:0] diag;
	} stick_cfg_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             scale;
		logic [7:0]       mag;
		logic             neg;
	} axis_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic             qb;
	} step_t;

	// one restoring division step at quotient bit sh
	function automatic step_t div_step(logic [NUM_W-1:0] rem, logic [DEN_W-1:0] den,
		logic [2:0] sh);
		logic [NUM_W-1:0] dsh;
		step_t r;
		dsh = NUM_W'(den) << sh;
		if (rem >= dsh) begin
			r.rem = rem - dsh;
			r.qb  = 1'b1;
		end else begin
			r.rem = rem;
			r.qb  = 1'b0;
		end
		return r;
	endfunction

endpackage

[sv/joystick_octagon_clamp.sv]
// top level of the joystick dead zone and octagon clamp
// depends on jocl_pkg, jocl_cfg, jocl_front, jocl_div and assert_macros.svh
//
//   channel   handshake        payload
//   request   start / busy     present, main_x_in, main_y_in, sub_x_in, sub_y_in,
//                              left_trig_in, right_trig_in
//   result    done             main_x_out, main_y_out, sub_x_out, sub_y_out,
//                              left_trig_out, right_trig_out
//   config    cfg_we           cfg_idx, cfg_wdata
//
// a request enters every cycle; its result shows for one cycle with done
// the 7-bit quotient takes two restoring steps a stage for three stages, then
// the last step and the sign restore, behind three stages of dead zone, divisor and numerators
// busy stays low; the pipeline never holds, so nothing waits on the result side
// reset clears the valid bits and loads the register reset values
`include "assert_macros.svh"

module joystick_octagon_clamp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	output logic                       done,
	input  logic                       present,
	input  logic signed [7:0]          main_x_in,
	input  logic signed [7:0]          main_y_in,
	input  logic signed [7:0]          sub_x_in,
	input  logic signed [7:0]          sub_y_in,
	input  logic [7:0]                 left_trig_in,
	input  logic [7:0]                 right_trig_in,
	output logic signed [7:0]          main_x_out,
	output logic signed [7:0]          main_y_out,
	output logic signed [7:0]          sub_x_out,
	output logic signed [7:0]          sub_y_out,
	output logic [7:0]                 left_trig_out,
	output logic [7:0]                 right_trig_out,
	input  logic                       cfg_we,
	input  logic [jocl_pkg::IDX_W-1:0] cfg_idx,
	input  logic [7:0]                 cfg_wdata
);
	import jocl_pkg::*;

	cfg_t       cfg;
	stick_cfg_t main_cfg, sub_cfg;
	axis_t      main_ax, main_ay, sub_ax, sub_ay;

	logic       vld_s   [1:LAT];
	logic [7:0] ltrig_s [1:LAT];
	logic [7:0] rtrig_s [1:LAT];
	logic [7:0] lt, rt;

	function automatic logic [7:0] trig_clamp(logic [7:0] t, logic [7:0] dz, logic [7:0] ceil);
		logic [7:0] tc;
		tc = (t > ceil) ? ceil : t;
		return (t <= dz) ? 8'd0 : 8'(tc - dz);
	endfunction

	assign busy = 1'b0;

	jocl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (reg_idx_t'(cfg_idx)),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_comb begin
		main_cfg.dz   = cfg.main_dz;
		main_cfg.rad  = cfg.main_rad;
		main_cfg.diag = cfg.main_diag;
		sub_cfg.dz    = cfg.sub_dz;
		sub_cfg.rad   = cfg.sub_rad;
		sub_cfg.diag  = cfg.sub_diag;
	end

	jocl_front u_main_front (
		.clk     (clk),
		.present (present),
		.x_in    (main_x_in),
		.y_in    (main_y_in),
		.scfg    (main_cfg),
		.ax      (main_ax),
		.ay      (main_ay)
	);

	jocl_front u_sub_front (
		.clk     (clk),
		.present (present),
		.x_in    (sub_x_in),
		.y_in    (sub_y_in),
		.scfg    (sub_cfg),
		.ax      (sub_ax),
		.ay      (sub_ay)
	);

	jocl_div u_main_x_div (.clk(clk), .a_in(main_ax), .val(main_x_out));
	jocl_div u_main_y_div (.clk(clk), .a_in(main_ay), .val(main_y_out));
	jocl_div u_sub_x_div  (.clk(clk), .a_in(sub_ax),  .val(sub_x_out));
	jocl_div u_sub_y_div  (.clk(clk), .a_in(sub_ay),  .val(sub_y_out));

	// triggers settle in stage 1, then ride along with the sticks
	always_comb begin
		lt = present ? trig_clamp(left_trig_in, cfg.trig_dz, cfg.trig_ceil) : left_trig_in;
		rt = present ? trig_clamp(right_trig_in, cfg.trig_dz, cfg.trig_ceil) : right_trig_in;
	end

	always_ff @(posedge clk) begin
		ltrig_s[1] <= lt;
		rtrig_s[1] <= rt;
		for (int i = 2; i <= LAT; i++) begin
			ltrig_s[i] <= ltrig_s[i-1];
			rtrig_s[i] <= rtrig_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[1] <= start && !busy;
			for (int i = 2; i <= LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	assign done           = vld_s[LAT];
	assign left_trig_out  = ltrig_s[LAT];
	assign right_trig_out = rtrig_s[LAT];

	`CHK_NOW(a_done_follows_start, done, $past(start, LAT), "result without a request")
	`CHK_NOW(a_bypass_main_x, done && !$past(present, LAT),
		main_x_out == $past(main_x_in, LAT), "absent controller did not pass main x")
	`CHK_NOW(a_bypass_sub_y, done && !$past(present, LAT),
		sub_y_out == $past(sub_y_in, LAT), "absent controller did not pass sub y")
	`CHK_NOW(a_trig_dead, done && $past(present, LAT) && ($past(left_trig_in, LAT) <= cfg.trig_dz),
		left_trig_out == 8'd0, "left trigger inside dead zone not zero")
	`CHK_NEXT(a_start_tracks, start && !busy, vld_s[1], "accepted request lost its valid bit")

endmodule

[sv/jocl_cfg.sv]
// configuration register file for the clamp
// depends on jocl_pkg
module jocl_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  jocl_pkg::reg_idx_t cfg_idx,
	input  logic [7:0]         cfg_wdata,
	output jocl_pkg::cfg_t     cfg
);
	import jocl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_dz   <= RST_TRIG_DZ;
			cfg_q.trig_ceil <= RST_TRIG_CEIL;
			cfg_q.main_dz   <= RST_MAIN_DZ;
			cfg_q.main_rad  <= RST_MAIN_RAD;
			cfg_q.main_diag <= RST_MAIN_DIAG;
			cfg_q.sub_dz    <= RST_SUB_DZ;
			cfg_q.sub_rad   <= RST_SUB_RAD;
			cfg_q.sub_diag  <= RST_SUB_DIAG;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TRIG_DZ:   cfg_q.trig_dz   <= cfg_wdata;
				REG_TRIG_CEIL: cfg_q.trig_ceil <= cfg_wdata;
				REG_MAIN_DZ:   cfg_q.main_dz   <= cfg_wdata[6:0];
				REG_MAIN_RAD:  cfg_q.main_rad  <= cfg_wdata[6:0];
				REG_MAIN_DIAG: cfg_q.main_diag <= cfg_wdata[6:0];
				REG_SUB_DZ:    cfg_q.sub_dz    <= cfg_wdata[6:0];
				REG_SUB_RAD:   cfg_q.sub_rad   <= cfg_wdata[6:0];
				REG_SUB_DIAG:  cfg_q.sub_diag  <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/jocl_front.sv]
// stick front end: dead zone, octagon divisor and scale numerators (stages 1 to 3)
// depends on jocl_pkg
module jocl_front (
	input  logic                clk,
	input  logic                present,
	input  logic signed [7:0]   x_in,
	input  logic signed [7:0]   y_in,
	input  jocl_pkg::stick_cfg_t scfg,
	output jocl_pkg::axis_t     ax,
	output jocl_pkg::axis_t     ay
);
	import jocl_pkg::*;

	logic [7:0] xa, ya, xd, yd, dz8;
	logic [7:0] xm_s1, ym_s1;
	logic       negx_s1, negy_s1, byp_s1;

	logic              swap;
	logic [7:0]        ma, mb;
	logic [14:0]       pa;
	logic signed [7:0] rmd;
	logic signed [16:0] pb, dsum;
	logic [13:0]       lim;
	logic signed [16:0] d_s2;
	logic [13:0]       lim_s2;
	logic [7:0]        xm_s2, ym_s2;
	logic              negx_s2, negy_s2, byp_s2;

	logic              scale;
	logic [21:0]       px, py;
	axis_t             ax_s3, ay_s3;

	// stage 1: magnitude and dead zone
	always_comb begin
		dz8 = {1'b0, scfg.dz};
		xa  = x_in[7] ? 8'(~x_in + 8'sd1) : 8'(x_in);
		ya  = y_in[7] ? 8'(~y_in + 8'sd1) : 8'(y_in);
		xd  = (xa <= dz8) ? 8'd0 : 8'(xa - dz8);
		yd  = (ya <= dz8) ? 8'd0 : 8'(ya - dz8);
	end

	always_ff @(posedge clk) begin
		if (present) begin
			xm_s1   <= xd;
			ym_s1   <= yd;
			negx_s1 <= x_in[7];
			negy_s1 <= y_in[7];
		end else begin
			xm_s1   <= 8'(x_in);
			ym_s1   <= 8'(y_in);
			negx_s1 <= 1'b0;
			negy_s1 <= 1'b0;
		end
		byp_s1 <= !present;
	end

	// stage 2: octagon divisor and limit
	always_comb begin
		swap = (scfg.diag != 7'd0) && (ym_s1 > xm_s1);
		ma   = swap ? ym_s1 : xm_s1;
		mb   = swap ? xm_s1 : ym_s1;
		pa   = 15'(scfg.diag) * 15'(ma);
		rmd  = $signed({1'b0, scfg.rad}) - $signed({1'b0, scfg.diag});
		pb   = 17'(rmd) * $signed({9'd0, mb});
		dsum = $signed({2'b00, pa}) + pb;
		lim  = 14'(scfg.diag) * 14'(scfg.rad);
	end

	always_ff @(posedge clk) begin
		d_s2    <= dsum;
		lim_s2  <= lim;
		xm_s2   <= xm_s1;
		ym_s2   <= ym_s1;
		negx_s2 <= negx_s1;
		negy_s2 <= negy_s1;
		byp_s2  <= byp_s1;
	end

	// stage 3: scale decision and numerators
	always_comb begin
		scale = !byp_s2 && ($signed({3'b000, lim_s2}) < d_s2);
		px    = 22'(lim_s2) * 22'(xm_s2);
		py    = 22'(lim_s2) * 22'(ym_s2);
	end

	always_ff @(posedge clk) begin
		ax_s3.num   <= px[NUM_W-1:0];
		ax_s3.den   <= d_s2[DEN_W-1:0];
		ax_s3.scale <= scale;
		ax_s3.mag   <= xm_s2;
		ax_s3.neg   <= negx_s2;
		ay_s3.num   <= py[NUM_W-1:0];
		ay_s3.den   <= d_s2[DEN_W-1:0];
		ay_s3.scale <= scale;
		ay_s3.mag   <= ym_s2;
		ay_s3.neg   <= negy_s2;
	end

	assign ax = ax_s3;
	assign ay = ay_s3;

endmodule

[sv/jocl_div.sv]
// pipelined restoring divider or magnitude bypass for one axis, two quotient bits a stage, last bit with sign restore
// depends on jocl_pkg (axis_t, div_step)
module jocl_div (
	input  logic              clk,
	input  jocl_pkg::axis_t   a_in,
	output logic signed [7:0] val
);
	import jocl_pkg::*;

	step_t st6, st5, st4, st3, st2, st1, st0;

	logic [NUM_W-1:0] rem_s4, rem_s5, rem_s6;
	logic [Q_W-1:0]   q_s4, q_s5, q_s6;
	logic [DEN_W-1:0] den_s4, den_s5, den_s6;
	logic             scale_s4, scale_s5, scale_s6;
	logic [7:0]       mag_s4, mag_s5, mag_s6;
	logic             neg_s4, neg_s5, neg_s6;

	logic [Q_W-1:0]   qf;
	logic [7:0]       m;
	logic [7:0]       val_s7;

	always_comb begin
		st6 = div_step(a_in.num, a_in.den, 3'd6);
		st5 = div_step(st6.rem, a_in.den, 3'd5);
		st4 = div_step(rem_s4, den_s4, 3'd4);
		st3 = div_step(st4.rem, den_s4, 3'd3);
		st2 = div_step(rem_s5, den_s5, 3'd2);
		st1 = div_step(st2.rem, den_s5, 3'd1);
		st0 = div_step(rem_s6, den_s6, 3'd0);
		qf  = q_s6 | {6'd0, st0.qb};
		m   = scale_s6 ? {1'b0, qf} : mag_s6;
	end

	always_ff @(posedge clk) begin
		rem_s4   <= st5.rem;
		q_s4     <= {st6.qb, st5.qb, 5'd0};
		den_s4   <= a_in.den;
		scale_s4 <= a_in.scale;
		mag_s4   <= a_in.mag;
		neg_s4   <= a_in.neg;

		rem_s5   <= st3.rem;
		q_s5     <= q_s4 | {2'd0, st4.qb, st3.qb, 3'd0};
		den_s5   <= den_s4;
		scale_s5 <= scale_s4;
		mag_s5   <= mag_s4;
		neg_s5   <= neg_s4;

		rem_s6   <= st1.rem;
		q_s6     <= q_s5 | {4'd0, st2.qb, st1.qb, 1'b0};
		den_s6   <= den_s5;
		scale_s6 <= scale_s5;
		mag_s6   <= mag_s5;
		neg_s6   <= neg_s5;

		// sign restore wraps to 8 bits
		val_s7   <= neg_s6 ? 8'(~m + 8'd1) : m;
	end

	assign val = $signed(val_s7);

endmodule
